>>> src/csetp_pkg.sv
`default_nettype none

package csetp_pkg;

  // Table sizes and field widths
  localparam int MAX_FUNCS   = 256;
  localparam int STACK_DEPTH = 64;
  localparam int TIME_W      = 32;
  localparam int ID_W        = 8;
  localparam int CFG_W       = 9;
  localparam int STAT_W      = 3;
  localparam int FUNC_AW     = $clog2(MAX_FUNCS);
  localparam int STACK_AW    = $clog2(STACK_DEPTH);
  localparam int LVL_W       = $clog2(STACK_DEPTH + 1);

  // Reset value of the function count register
  localparam logic [CFG_W-1:0] FUNC_COUNT_RST = CFG_W'(MAX_FUNCS);

  // Event kinds
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_END   = 1'b1;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_OVERFLOW = 3'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [STAT_W-1:0] ST_MISMATCH = 3'd3;
  localparam logic [STAT_W-1:0] ST_RANGE    = 3'd4;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic cfg_we;   // write func_count
    logic capture;  // latch an input beat
    logic calc;     // elapsed time and checks
    logic commit;   // table updates and result register load
  } cmd_t;

endpackage

`default_nettype wire

>>> src/csetp_ram.sv
`default_nettype none

module csetp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire  logic                     clk,
  input  wire  logic                     we,
  input  wire  logic [$clog2(DEPTH)-1:0] waddr,
  input  wire  logic [WIDTH-1:0]         wdata,
  input  wire  logic [$clog2(DEPTH)-1:0] raddr,
  output logic       [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port (read-first)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> src/csetp_ctrl.sv
`default_nettype none

module csetp_ctrl (
  input  wire  logic              clk,
  input  wire  logic              rst,
  input  wire  logic              in_valid,
  output logic                    in_stall,
  output logic                    out_valid,
  input  wire  logic              out_stall,
  input  wire  logic              cfg_valid,
  output logic                    cfg_ready,
  output csetp_pkg::cmd_t         cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CALC,
    S_UPDATE
  } state_t;

  state_t state;
  logic   out_free;

  // Output register can take a new result this cycle
  assign out_free = !out_valid || !out_stall;

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);

  // Command decode
  always_comb begin
    cmd         = '0;
    cmd.cfg_we  = cfg_valid && (state == S_IDLE);
    cmd.capture = in_valid && (state == S_IDLE);
    cmd.calc    = (state == S_CALC);
    cmd.commit  = (state == S_UPDATE) && out_free;
  end

  // State and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_CALC;
          end
        end
        S_CALC: begin
          state <= S_UPDATE;
        end
        S_UPDATE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // A commit never overwrites a result that is still stalled
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !(out_valid && out_stall))
    else $error("result overwritten while stalled");

  // An accepted beat always goes through the calc cycle next
  a_accept_calc: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_CALC))
    else $error("accepted beat did not enter calc");

  // Calc is always followed by the update state
  a_calc_update: assert property (@(posedge clk) disable iff (rst)
    (state == S_CALC) |=> (state == S_UPDATE))
    else $error("calc not followed by update");

  // Every commit leaves a valid result on the output
  a_commit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("commit did not raise out_valid");

endmodule

`default_nettype wire

>>> src/csetp_dp.sv
`default_nettype none

module csetp_dp (
  input  wire  logic                                clk,
  input  wire  logic                                rst,
  input  wire  csetp_pkg::cmd_t                     cmd,
  input  wire  logic [csetp_pkg::CFG_W-1:0]         cfg_data,
  input  wire  logic                                action,
  input  wire  logic [csetp_pkg::ID_W-1:0]          function_id,
  input  wire  logic [csetp_pkg::TIME_W-1:0]        timestamp,
  output logic                                      credited_valid,
  output logic       [csetp_pkg::ID_W-1:0]          credited_id,
  output logic       [csetp_pkg::TIME_W-1:0]        credited_total,
  output logic       [csetp_pkg::STAT_W-1:0]        status
);

  localparam logic [csetp_pkg::TIME_W-1:0] TIME_MAX = '1;

  // Control state
  logic [csetp_pkg::CFG_W-1:0]     func_count;
  logic [csetp_pkg::LVL_W-1:0]     level;
  logic [csetp_pkg::MAX_FUNCS-1:0] tot_valid;

  // Payload registers
  logic [csetp_pkg::ID_W-1:0]      top_id;
  logic                            act_r;
  logic [csetp_pkg::ID_W-1:0]      id_r;
  logic [csetp_pkg::TIME_W-1:0]    now_r;
  logic [csetp_pkg::TIME_W-1:0]    elapsed_r;
  logic [csetp_pkg::STAT_W-1:0]    stat_r;
  logic                            credit_r;

  // RAM ports
  logic                            stk_we;
  logic [csetp_pkg::STACK_AW-1:0]  stk_waddr;
  logic [csetp_pkg::STACK_AW-1:0]  stk_raddr;
  logic [csetp_pkg::ID_W-1:0]      stk_q;
  logic                            res_we;
  logic [csetp_pkg::FUNC_AW-1:0]   res_waddr;
  logic [csetp_pkg::TIME_W-1:0]    res_wdata;
  logic [csetp_pkg::TIME_W-1:0]    res_q;
  logic                            tot_we;
  logic [csetp_pkg::TIME_W-1:0]    tot_q;

  // Combinational helpers
  logic [csetp_pkg::LVL_W-1:0]     level_m2;
  logic                            oor;
  logic [csetp_pkg::STAT_W-1:0]    stat_next;
  logic                            credit_next;
  logic [csetp_pkg::TIME_W-1:0]    tot_cur;
  logic [csetp_pkg::TIME_W+1:0]    sum;
  logic [csetp_pkg::TIME_W-1:0]    tot_sat;
  logic [csetp_pkg::TIME_W-1:0]    now_inc;
  logic                            op_ok;

  // Read addresses come from stable state: credited id is always the top
  assign level_m2  = level - csetp_pkg::LVL_W'(2);
  assign stk_raddr = level_m2[csetp_pkg::STACK_AW-1:0];

  csetp_ram #(
    .WIDTH (csetp_pkg::ID_W),
    .DEPTH (csetp_pkg::STACK_DEPTH)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (id_r),
    .raddr (stk_raddr),
    .rdata (stk_q)
  );

  csetp_ram #(
    .WIDTH (csetp_pkg::TIME_W),
    .DEPTH (csetp_pkg::MAX_FUNCS)
  ) u_resume_ram (
    .clk   (clk),
    .we    (res_we),
    .waddr (res_waddr),
    .wdata (res_wdata),
    .raddr (top_id[csetp_pkg::FUNC_AW-1:0]),
    .rdata (res_q)
  );

  csetp_ram #(
    .WIDTH (csetp_pkg::TIME_W),
    .DEPTH (csetp_pkg::MAX_FUNCS)
  ) u_total_ram (
    .clk   (clk),
    .we    (tot_we),
    .waddr (top_id[csetp_pkg::FUNC_AW-1:0]),
    .wdata (tot_sat),
    .raddr (top_id[csetp_pkg::FUNC_AW-1:0]),
    .rdata (tot_q)
  );

  // Event checks, in priority order
  assign oor = {1'b0, id_r} >= func_count;

  always_comb begin
    stat_next   = csetp_pkg::ST_OK;
    credit_next = 1'b0;
    if (oor) begin
      stat_next = csetp_pkg::ST_RANGE;
    end else if (act_r == csetp_pkg::ACT_START) begin
      if (level == csetp_pkg::LVL_W'(csetp_pkg::STACK_DEPTH)) begin
        stat_next = csetp_pkg::ST_OVERFLOW;
      end else begin
        credit_next = (level != '0);
      end
    end else begin
      if (level == '0) begin
        stat_next = csetp_pkg::ST_EMPTY;
      end else if (top_id != id_r) begin
        stat_next = csetp_pkg::ST_MISMATCH;
      end else begin
        credit_next = 1'b1;
      end
    end
  end

  // Saturating total update; an end adds one extra tick
  assign tot_cur = tot_valid[top_id[csetp_pkg::FUNC_AW-1:0]] ? tot_q : '0;
  assign sum     = {2'b00, tot_cur} + {2'b00, elapsed_r}
                 + {{(csetp_pkg::TIME_W+1){1'b0}}, act_r};
  assign tot_sat = (sum[csetp_pkg::TIME_W+1:csetp_pkg::TIME_W] != 2'b00)
                 ? TIME_MAX : sum[csetp_pkg::TIME_W-1:0];
  assign now_inc = (now_r == TIME_MAX) ? TIME_MAX : now_r + csetp_pkg::TIME_W'(1);

  assign op_ok = cmd.commit && (stat_r == csetp_pkg::ST_OK);

  // Table writes at commit
  always_comb begin
    stk_we    = op_ok && (act_r == csetp_pkg::ACT_START);
    stk_waddr = level[csetp_pkg::STACK_AW-1:0];
    tot_we    = cmd.commit && credit_r;
    res_we    = 1'b0;
    res_waddr = id_r[csetp_pkg::FUNC_AW-1:0];
    res_wdata = now_r;
    if (op_ok) begin
      if (act_r == csetp_pkg::ACT_START) begin
        res_we = 1'b1;
      end else if (level > csetp_pkg::LVL_W'(1)) begin
        res_we    = 1'b1;
        res_waddr = stk_q[csetp_pkg::FUNC_AW-1:0];
        res_wdata = now_inc;
      end
    end
  end

  // Control state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      func_count <= csetp_pkg::FUNC_COUNT_RST;
      level      <= '0;
      tot_valid  <= '0;
    end else begin
      if (cmd.cfg_we) begin
        func_count <= cfg_data;
      end
      if (tot_we) begin
        tot_valid[top_id[csetp_pkg::FUNC_AW-1:0]] <= 1'b1;
      end
      if (op_ok) begin
        if (act_r == csetp_pkg::ACT_START) begin
          level <= level + csetp_pkg::LVL_W'(1);
        end else begin
          level <= level - csetp_pkg::LVL_W'(1);
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r <= action;
      id_r  <= function_id;
      now_r <= timestamp;
    end
    if (cmd.calc) begin
      elapsed_r <= (now_r >= res_q) ? now_r - res_q : '0;
      stat_r    <= stat_next;
      credit_r  <= credit_next;
    end
    if (op_ok) begin
      if (act_r == csetp_pkg::ACT_START) begin
        top_id <= id_r;
      end else begin
        top_id <= stk_q;
      end
    end
    if (cmd.commit) begin
      credited_valid <= credit_r;
      credited_id    <= credit_r ? top_id : '0;
      credited_total <= credit_r ? tot_sat : '0;
      status         <= stat_r;
    end
  end

  // Stack level stays within its depth
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    level <= csetp_pkg::LVL_W'(csetp_pkg::STACK_DEPTH))
    else $error("stack level beyond depth");

  // A credit only ever comes with an ok status
  a_credit_ok: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && credit_r) |-> (stat_r == csetp_pkg::ST_OK))
    else $error("credit with error status");

  // A rejected event leaves the stack level untouched
  a_error_hold: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && stat_r != csetp_pkg::ST_OK) |=> $stable(level))
    else $error("stack level changed on rejected event");

endmodule

`default_nettype wire

>>> src/call_stack_exclusive_time_profiler.sv
// Flow: an accepted beat is captured, then goes through calc and update; update waits while
//   the output is stalled. A new event is taken only once the last is done, after the read,
//   elapsed-time and read-modify-write steps through the registered-read table RAMs.
// Reset (rst, synchronous): empties the stack, sets func_count to 256 and clears the
//   per-id total valid bits, so all totals read as zero at once; no clearing pass.
`default_nettype none

module call_stack_exclusive_time_profiler (
  input  wire  logic                               clk,
  input  wire  logic                               rst,
  input  wire  logic                               in_valid,
  output logic                                     in_stall,
  input  wire  logic                               action,
  input  wire  logic [csetp_pkg::ID_W-1:0]         function_id,
  input  wire  logic [csetp_pkg::TIME_W-1:0]       timestamp,
  output logic                                     out_valid,
  input  wire  logic                               out_stall,
  output logic                                     credited_valid,
  output logic       [csetp_pkg::ID_W-1:0]         credited_id,
  output logic       [csetp_pkg::TIME_W-1:0]       credited_total,
  output logic       [csetp_pkg::STAT_W-1:0]       status,
  input  wire  logic                               cfg_valid,
  output logic                                     cfg_ready,
  input  wire  logic [csetp_pkg::CFG_W-1:0]        cfg_data
);

  csetp_pkg::cmd_t cmd;

  // Sequencer
  csetp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cmd       (cmd)
  );

  // Stack, tables and arithmetic
  csetp_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .cfg_data       (cfg_data),
    .action         (action),
    .function_id    (function_id),
    .timestamp      (timestamp),
    .credited_valid (credited_valid),
    .credited_id    (credited_id),
    .credited_total (credited_total),
    .status         (status)
  );

endmodule

`default_nettype wire
